// ===== hw/rtl/stl_pkg.sv =====
// stl_pkg: shared widths, micro-op codes and the micro-op table for the
// least-squares similarity transform block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

    // field and accumulator widths
    localparam int COORD_W         = 16;
    localparam int LIN_W           = 22;
    localparam int SQ_W            = 40;
    localparam int SPLIT           = 20;
    localparam int MAC_W           = 64;
    localparam int OPND_W          = 32;
    localparam int OUT_W           = 32;
    localparam int DVD_W           = 64;
    localparam int DEN_W           = 48;
    localparam int NDEN_SHIFT      = 12;
    localparam int MAX_POINTS_DEF  = 64;

    // saturation limits of the 32 bit results
    localparam logic [OUT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_MIN = 32'h8000_0000;

    // multiplier operand sources
    localparam int OPD_NUM = 18;
    localparam logic [4:0] OPD_X   = 5'd0;
    localparam logic [4:0] OPD_Y   = 5'd1;
    localparam logic [4:0] OPD_DX  = 5'd2;
    localparam logic [4:0] OPD_DY  = 5'd3;
    localparam logic [4:0] OPD_N   = 5'd4;
    localparam logic [4:0] OPD_SQH = 5'd5;
    localparam logic [4:0] OPD_SQL = 5'd6;
    localparam logic [4:0] OPD_DTH = 5'd7;
    localparam logic [4:0] OPD_DTL = 5'd8;
    localparam logic [4:0] OPD_CRH = 5'd9;
    localparam logic [4:0] OPD_CRL = 5'd10;
    localparam logic [4:0] OPD_SX  = 5'd11;
    localparam logic [4:0] OPD_SY  = 5'd12;
    localparam logic [4:0] OPD_SDX = 5'd13;
    localparam logic [4:0] OPD_SDY = 5'd14;
    localparam logic [4:0] OPD_A   = 5'd15;
    localparam logic [4:0] OPD_B   = 5'd16;
    localparam logic [4:0] OPD_K16 = 5'd17;

    // product destinations
    localparam logic [1:0] DST_SSQ = 2'd0;
    localparam logic [1:0] DST_DOT = 2'd1;
    localparam logic [1:0] DST_CR  = 2'd2;
    localparam logic [1:0] DST_ACC = 2'd3;

    // accumulator save targets
    localparam logic [1:0] SV_NONE = 2'd0;
    localparam logic [1:0] SV_DET  = 2'd1;
    localparam logic [1:0] SV_AN   = 2'd2;
    localparam logic [1:0] SV_BN   = 2'd3;

    // program entry points
    localparam logic [4:0] OP_ACC = 5'd0;
    localparam logic [4:0] OP_DET = 5'd6;
    localparam logic [4:0] OP_AB  = 5'd10;
    localparam logic [4:0] OP_TX  = 5'd18;
    localparam logic [4:0] OP_TY  = 5'd21;
    localparam logic [4:0] OP_END = 5'd24;

    typedef struct packed {
        logic [4:0] a_sel;
        logic [4:0] b_sel;
        logic       neg;
        logic       shl;
        logic       first;
        logic [1:0] dest;
        logic [1:0] save;
        logic       last;
    } op_t;

    function automatic op_t mk_op(input logic [4:0] a, input logic [4:0] b,
                                  input logic neg, input logic shl,
                                  input logic first, input logic [1:0] dest,
                                  input logic [1:0] save, input logic last);
        op_t op;
        op.a_sel = a;
        op.b_sel = b;
        op.neg   = neg;
        op.shl   = shl;
        op.first = first;
        op.dest  = dest;
        op.save  = save;
        op.last  = last;
        return op;
    endfunction

    // micro-op table: one multiply-accumulate per entry
    function automatic op_t stl_op(input logic [4:0] idx);
        op_t op;
        op = '0;
        case (idx)
            // per-pair products
            5'd0:  op = mk_op(OPD_X,   OPD_X,   1'b0, 1'b0, 1'b0, DST_SSQ, SV_NONE, 1'b0);
            5'd1:  op = mk_op(OPD_Y,   OPD_Y,   1'b0, 1'b0, 1'b0, DST_SSQ, SV_NONE, 1'b0);
            5'd2:  op = mk_op(OPD_X,   OPD_DX,  1'b0, 1'b0, 1'b0, DST_DOT, SV_NONE, 1'b0);
            5'd3:  op = mk_op(OPD_Y,   OPD_DY,  1'b0, 1'b0, 1'b0, DST_DOT, SV_NONE, 1'b0);
            5'd4:  op = mk_op(OPD_X,   OPD_DY,  1'b0, 1'b0, 1'b0, DST_CR,  SV_NONE, 1'b0);
            5'd5:  op = mk_op(OPD_Y,   OPD_DX,  1'b1, 1'b0, 1'b0, DST_CR,  SV_NONE, 1'b1);
            // determinant
            5'd6:  op = mk_op(OPD_SQH, OPD_N,   1'b0, 1'b1, 1'b1, DST_ACC, SV_NONE, 1'b0);
            5'd7:  op = mk_op(OPD_SQL, OPD_N,   1'b0, 1'b0, 1'b0, DST_ACC, SV_NONE, 1'b0);
            5'd8:  op = mk_op(OPD_SX,  OPD_SX,  1'b1, 1'b0, 1'b0, DST_ACC, SV_NONE, 1'b0);
            5'd9:  op = mk_op(OPD_SY,  OPD_SY,  1'b1, 1'b0, 1'b0, DST_ACC, SV_DET,  1'b1);
            // numerator of a
            5'd10: op = mk_op(OPD_DTH, OPD_N,   1'b0, 1'b1, 1'b1, DST_ACC, SV_NONE, 1'b0);
            5'd11: op = mk_op(OPD_DTL, OPD_N,   1'b0, 1'b0, 1'b0, DST_ACC, SV_NONE, 1'b0);
            5'd12: op = mk_op(OPD_SX,  OPD_SDX, 1'b1, 1'b0, 1'b0, DST_ACC, SV_NONE, 1'b0);
            5'd13: op = mk_op(OPD_SY,  OPD_SDY, 1'b1, 1'b0, 1'b0, DST_ACC, SV_AN,   1'b0);
            // numerator of b
            5'd14: op = mk_op(OPD_CRH, OPD_N,   1'b0, 1'b1, 1'b1, DST_ACC, SV_NONE, 1'b0);
            5'd15: op = mk_op(OPD_CRL, OPD_N,   1'b0, 1'b0, 1'b0, DST_ACC, SV_NONE, 1'b0);
            5'd16: op = mk_op(OPD_SY,  OPD_SDX, 1'b0, 1'b0, 1'b0, DST_ACC, SV_NONE, 1'b0);
            5'd17: op = mk_op(OPD_SX,  OPD_SDY, 1'b1, 1'b0, 1'b0, DST_ACC, SV_BN,   1'b1);
            // numerator of tx
            5'd18: op = mk_op(OPD_SDX, OPD_K16, 1'b0, 1'b0, 1'b1, DST_ACC, SV_NONE, 1'b0);
            5'd19: op = mk_op(OPD_A,   OPD_SX,  1'b1, 1'b0, 1'b0, DST_ACC, SV_NONE, 1'b0);
            5'd20: op = mk_op(OPD_B,   OPD_SY,  1'b0, 1'b0, 1'b0, DST_ACC, SV_NONE, 1'b1);
            // numerator of ty
            5'd21: op = mk_op(OPD_SDY, OPD_K16, 1'b0, 1'b0, 1'b1, DST_ACC, SV_NONE, 1'b0);
            5'd22: op = mk_op(OPD_A,   OPD_SY,  1'b1, 1'b0, 1'b0, DST_ACC, SV_NONE, 1'b0);
            5'd23: op = mk_op(OPD_B,   OPD_SX,  1'b1, 1'b0, 1'b0, DST_ACC, SV_NONE, 1'b1);
            default: op = '0;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/similarity_transform_lsq.sv =====
// Least-squares 2-D similarity transform estimator, top level.
// Depends on stl_pkg and stl_div.
`timescale 1ns / 1ps
`default_nettype none

// Point pairs arrive one per request; a request with last_pair set closes the
// set and produces one result [[a,-b,tx],[b,a,ty]] with a, b in Q15.16 and
// tx, ty in Q27.4, all saturated; singular is set with zero fields when the
// determinant is not positive. Pairs past MAX_POINTS are not accumulated.
// Every product goes through one shared 32x32 multiplier with a registered
// accumulate stage, run by a micro-op sequencer: a pair that is accumulated
// is accepted, has its six products issued and then waits for the pipeline
// to drain; a pair beyond MAX_POINTS is accepted without any products. The
// closing pair then runs the solve: 18 multiply-accumulates with their drains
// and four 64-step divisions of the bit-serial divider (a, b, tx, ty). Input
// is not taken during that time; a finished result waits in the output
// register while the next set is accumulated.
module similarity_transform_lsq
#(
    parameter int MAX_POINTS = stl_pkg::MAX_POINTS_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [stl_pkg::COORD_W-1:0] src_x,
    input  wire logic signed [stl_pkg::COORD_W-1:0] src_y,
    input  wire logic signed [stl_pkg::COORD_W-1:0] dst_x,
    input  wire logic signed [stl_pkg::COORD_W-1:0] dst_y,
    input  wire logic                               last_pair,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [stl_pkg::OUT_W-1:0]        scale_cos,
    output logic signed [stl_pkg::OUT_W-1:0]        scale_sin,
    output logic signed [stl_pkg::OUT_W-1:0]        shift_x,
    output logic signed [stl_pkg::OUT_W-1:0]        shift_y,
    output logic                                    singular
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int COORD_W = stl_pkg::COORD_W;
    localparam int LIN_W  = stl_pkg::LIN_W;
    localparam int SQ_W   = stl_pkg::SQ_W;
    localparam int SPLIT  = stl_pkg::SPLIT;
    localparam int MAC_W  = stl_pkg::MAC_W;
    localparam int OPND_W = stl_pkg::OPND_W;
    localparam int OUT_W  = stl_pkg::OUT_W;
    localparam int DVD_W  = stl_pkg::DVD_W;
    localparam int DEN_W  = stl_pkg::DEN_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAC  = 4'd1;
    localparam logic [3:0] S_WAIT = 4'd2;
    localparam logic [3:0] S_DIVA = 4'd3;
    localparam logic [3:0] S_DIVB = 4'd4;
    localparam logic [3:0] S_DIVX = 4'd5;
    localparam logic [3:0] S_DIVY = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    // sequencer
    logic [3:0]  state_reg;
    logic [4:0]  op_idx_reg;
    logic        last_reg;
    logic        sing_reg;

    // accumulators
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [LIN_W-1:0]  sx_reg;
    logic signed [LIN_W-1:0]  sy_reg;
    logic signed [LIN_W-1:0]  sdx_reg;
    logic signed [LIN_W-1:0]  sdy_reg;
    logic signed [SQ_W-1:0]   ssq_reg;
    logic signed [SQ_W-1:0]   sdot_reg;
    logic signed [SQ_W-1:0]   scr_reg;

    // latched pair
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [COORD_W-1:0] dx_reg;
    logic signed [COORD_W-1:0] dy_reg;

    // solve intermediates
    logic signed [MAC_W-1:0]  acc_reg;
    logic [DEN_W-1:0]         det_reg;
    logic [DEN_W-1:0]         an_reg;
    logic [DEN_W-1:0]         bn_reg;
    logic signed [OUT_W-1:0]  a_reg;
    logic signed [OUT_W-1:0]  b_reg;
    logic signed [OUT_W-1:0]  tx_reg;
    logic signed [OUT_W-1:0]  ty_reg;

    // multiplier pipeline
    stl_pkg::op_t             cur_op;
    stl_pkg::op_t             pop_reg;
    logic                     p_vld_reg;
    logic signed [OPND_W-1:0] opnd [stl_pkg::OPD_NUM];
    logic signed [OPND_W-1:0] mul_a;
    logic signed [OPND_W-1:0] mul_b;
    logic signed [MAC_W-1:0]  prod_next;
    logic signed [MAC_W-1:0]  prod_reg;
    logic signed [MAC_W-1:0]  pshift;
    logic signed [MAC_W-1:0]  padd;
    logic signed [MAC_W-1:0]  acc_next;

    // divider hookup
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [DEN_W-1:0]  div_dvs;
    logic              div_done;
    logic [OUT_W-1:0]  div_q;
    logic [DEN_W-1:0]  nden;

    logic take;
    logic accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;
    assign take     = (cnt_reg < CNT_W'(MAX_POINTS));
    assign nden     = DEN_W'({cnt_reg, {stl_pkg::NDEN_SHIFT{1'b0}}});

    // operand sources of the shared multiplier
    always_comb
    begin
        opnd[stl_pkg::OPD_X]   = OPND_W'(x_reg);
        opnd[stl_pkg::OPD_Y]   = OPND_W'(y_reg);
        opnd[stl_pkg::OPD_DX]  = OPND_W'(dx_reg);
        opnd[stl_pkg::OPD_DY]  = OPND_W'(dy_reg);
        opnd[stl_pkg::OPD_N]   = OPND_W'(cnt_reg);
        opnd[stl_pkg::OPD_SQH] = OPND_W'($signed(ssq_reg[SQ_W-1:SPLIT]));
        opnd[stl_pkg::OPD_SQL] = OPND_W'(ssq_reg[SPLIT-1:0]);
        opnd[stl_pkg::OPD_DTH] = OPND_W'($signed(sdot_reg[SQ_W-1:SPLIT]));
        opnd[stl_pkg::OPD_DTL] = OPND_W'(sdot_reg[SPLIT-1:0]);
        opnd[stl_pkg::OPD_CRH] = OPND_W'($signed(scr_reg[SQ_W-1:SPLIT]));
        opnd[stl_pkg::OPD_CRL] = OPND_W'(scr_reg[SPLIT-1:0]);
        opnd[stl_pkg::OPD_SX]  = OPND_W'(sx_reg);
        opnd[stl_pkg::OPD_SY]  = OPND_W'(sy_reg);
        opnd[stl_pkg::OPD_SDX] = OPND_W'(sdx_reg);
        opnd[stl_pkg::OPD_SDY] = OPND_W'(sdy_reg);
        opnd[stl_pkg::OPD_A]   = a_reg;
        opnd[stl_pkg::OPD_B]   = b_reg;
        opnd[stl_pkg::OPD_K16] = 32'sd65536;
    end

    // issue stage
    assign cur_op    = stl_pkg::stl_op(op_idx_reg);
    assign mul_a     = opnd[cur_op.a_sel];
    assign mul_b     = opnd[cur_op.b_sel];
    assign prod_next = MAC_W'(mul_a) * MAC_W'(mul_b);

    // accumulate stage
    assign pshift   = pop_reg.shl ? (prod_reg <<< SPLIT) : prod_reg;
    assign padd     = pop_reg.neg ? -pshift : pshift;
    assign acc_next = (pop_reg.first ? '0 : acc_reg) + padd;

    // divider requests
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        if (state_reg == S_WAIT && !p_vld_reg)
        begin
            if (op_idx_reg == stl_pkg::OP_TX)
            begin
                div_start = 1'b1;
                div_dvd   = {an_reg, 16'b0};
                div_dvs   = det_reg;
            end
            else if (op_idx_reg == stl_pkg::OP_TY || op_idx_reg == stl_pkg::OP_END)
            begin
                div_start = 1'b1;
                div_dvd   = acc_reg;
                div_dvs   = nden;
            end
        end
        else if (state_reg == S_DIVA && div_done)
        begin
            div_start = 1'b1;
            div_dvd   = {bn_reg, 16'b0};
            div_dvs   = det_reg;
        end
    end

    stl_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer, accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_idx_reg <= stl_pkg::OP_ACC;
            last_reg   <= 1'b0;
            sing_reg   <= 1'b0;
            p_vld_reg  <= 1'b0;
            out_valid  <= 1'b0;
            cnt_reg    <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            sdx_reg    <= '0;
            sdy_reg    <= '0;
            ssq_reg    <= '0;
            sdot_reg   <= '0;
            scr_reg    <= '0;
        end
        else
        begin
            p_vld_reg <= (state_reg == S_MAC);

            // product accumulate
            if (p_vld_reg)
            begin
                unique case (pop_reg.dest)
                    stl_pkg::DST_SSQ: ssq_reg  <= ssq_reg + padd[SQ_W-1:0];
                    stl_pkg::DST_DOT: sdot_reg <= sdot_reg + padd[SQ_W-1:0];
                    stl_pkg::DST_CR:  scr_reg  <= scr_reg + padd[SQ_W-1:0];
                    default:          ;
                endcase
            end

            // result handshake: held while waiting, raised when a result loads
            if (state_reg == S_OUT)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= last_pair;
                        if (take)
                        begin
                            cnt_reg    <= cnt_reg + 1'b1;
                            sx_reg     <= sx_reg + LIN_W'(src_x);
                            sy_reg     <= sy_reg + LIN_W'(src_y);
                            sdx_reg    <= sdx_reg + LIN_W'(dst_x);
                            sdy_reg    <= sdy_reg + LIN_W'(dst_y);
                            op_idx_reg <= stl_pkg::OP_ACC;
                            state_reg  <= S_MAC;
                        end
                        else
                        begin
                            op_idx_reg <= stl_pkg::OP_DET;
                            state_reg  <= last_pair ? S_MAC : S_IDLE;
                        end
                    end
                end
                S_MAC:
                begin
                    op_idx_reg <= op_idx_reg + 1'b1;
                    if (cur_op.last)
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (!p_vld_reg)
                    begin
                        case (op_idx_reg)
                            stl_pkg::OP_DET: state_reg <= last_reg ? S_MAC : S_IDLE;
                            stl_pkg::OP_AB:
                            begin
                                if (acc_reg <= 0)
                                begin
                                    sing_reg  <= 1'b1;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_MAC;
                                end
                            end
                            stl_pkg::OP_TX:  state_reg <= S_DIVA;
                            stl_pkg::OP_TY:  state_reg <= S_DIVX;
                            stl_pkg::OP_END: state_reg <= S_DIVY;
                            default:         state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_DIVA:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DIVB;
                    end
                end
                S_DIVB:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_MAC;
                    end
                end
                S_DIVX:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_MAC;
                    end
                end
                S_DIVY:
                begin
                    if (div_done)
                    begin
                        sing_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid || out_ready)
                    begin
                        cnt_reg   <= '0;
                        sx_reg    <= '0;
                        sy_reg    <= '0;
                        sdx_reg   <= '0;
                        sdy_reg   <= '0;
                        ssq_reg   <= '0;
                        sdot_reg  <= '0;
                        scr_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        pop_reg  <= cur_op;

        if (accept)
        begin
            x_reg  <= src_x;
            y_reg  <= src_y;
            dx_reg <= dst_x;
            dy_reg <= dst_y;
        end

        // solve accumulator and saved terms
        if (p_vld_reg && pop_reg.dest == stl_pkg::DST_ACC)
        begin
            acc_reg <= acc_next;
            unique case (pop_reg.save)
                stl_pkg::SV_DET: det_reg <= acc_next[DEN_W-1:0];
                stl_pkg::SV_AN:  an_reg  <= acc_next[DEN_W-1:0];
                stl_pkg::SV_BN:  bn_reg  <= acc_next[DEN_W-1:0];
                default:         ;
            endcase
        end

        // quotients
        if (div_done)
        begin
            unique case (state_reg)
                S_DIVA:  a_reg  <= div_q;
                S_DIVB:  b_reg  <= div_q;
                S_DIVX:  tx_reg <= div_q;
                S_DIVY:  ty_reg <= div_q;
                default: ;
            endcase
        end

        // result out
        if (state_reg == S_OUT && (!out_valid || out_ready))
        begin
            singular  <= sing_reg;
            scale_cos <= sing_reg ? '0 : a_reg;
            scale_sin <= sing_reg ? '0 : b_reg;
            shift_x   <= sing_reg ? '0 : tx_reg;
            shift_y   <= sing_reg ? '0 : ty_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stl_div.sv =====
// stl_div: bit-serial signed divider with round-half-away-from-zero and
// 32 bit saturation of the quotient. Depends on stl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stl_div
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [stl_pkg::DVD_W-1:0]   dividend,
    input  wire logic [stl_pkg::DEN_W-1:0]   divisor,
    output logic                             done,
    output logic [stl_pkg::OUT_W-1:0]        quotient
);

    localparam int DVD_W = stl_pkg::DVD_W;
    localparam int DEN_W = stl_pkg::DEN_W;
    localparam int OUT_W = stl_pkg::OUT_W;
    localparam int CNT_W = $clog2(DVD_W);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;

    logic [1:0]        state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic              ovf_reg;
    logic [DVD_W-1:0]  mag_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [OUT_W:0]    q_reg;

    logic [DVD_W-1:0]  abs_dvd;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W+1:0]  diff;
    logic              ge;
    logic              big_pos;
    logic              big_neg;
    logic [OUT_W-1:0]  sat_q;

    // magnitude of the dividend; half the divisor is added for rounding on load
    assign abs_dvd = dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;

    // one restoring step
    assign rem_sh = {rem_reg, mag_reg[DVD_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};
    assign ge     = ~diff[DEN_W+1];

    // clamp to the signed 32 bit range
    assign big_pos = ovf_reg | q_reg[OUT_W] | q_reg[OUT_W-1];
    assign big_neg = ovf_reg | q_reg[OUT_W] | (q_reg[OUT_W-1] & (|q_reg[OUT_W-2:0]));
    always_comb
    begin
        if (neg_reg)
        begin
            sat_q = big_neg ? stl_pkg::SAT_MIN : (~q_reg[OUT_W-1:0] + 1'b1);
        end
        else
        begin
            sat_q = big_pos ? stl_pkg::SAT_MAX : q_reg[OUT_W-1:0];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DVD_W - 1))
                    begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN:
                begin
                    done      <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            neg_reg <= dividend[DVD_W-1];
            mag_reg <= abs_dvd + DVD_W'(divisor >> 1);
            den_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (state_reg == D_RUN)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            mag_reg <= {mag_reg[DVD_W-2:0], 1'b0};
            q_reg   <= {q_reg[OUT_W-1:0], ge};
            ovf_reg <= ovf_reg | q_reg[OUT_W];
        end
        else if (state_reg == D_FIN)
        begin
            quotient <= sat_q;
        end
    end

endmodule

`default_nettype wire
